### design/i8080ie_pkg.sv
// Package for the 8080 instruction encoder: request and response structs,
// the encoded-instruction bundle and the status codes. No dependencies.
package i8080ie_pkg;

   typedef enum logic [2:0] {
      STATUS_OK       = 3'd0,
      STATUS_BAD_MNEM = 3'd1,
      STATUS_BAD_REG  = 3'd2,
      STATUS_BAD_BYTE = 3'd3,
      STATUS_BAD_RST  = 3'd4
   } status_type;

   typedef struct packed {
      logic [39:0] mnemonic;
      logic [39:0] first_operand;
      logic [39:0] second_operand;
      logic [15:0] immediate;
   } req_type;

   typedef struct packed {
      logic [7:0] code_byte;
      logic       last_byte;
      logic [2:0] status;
   } rsp_type;

   // One encoded instruction: up to three bytes, how many, and the status.
   typedef struct packed {
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic [7:0] byte2;
      logic [1:0] count;
      status_type status;
   } enc_type;

endpackage

### design/i8080ie_decoder.sv
// Combinational instruction encoder: turns one registered request into an
// encoded bundle of one to three bytes. Depends on i8080ie_pkg.
module i8080ie_decoder (
   input  i8080ie_pkg::req_type req,
   output i8080ie_pkg::enc_type enc
);
   import i8080ie_pkg::*;

   typedef enum logic [3:0] {
      K_NONE, K_IMPLIED, K_REG, K_PAIR, K_BYTE, K_WORD, K_MOV, K_MVI, K_LXI, K_RST
   } kind_type;

   localparam logic [4:0] ALLOW_BC  = 5'b00001;
   localparam logic [4:0] ALLOW_DE  = 5'b00010;
   localparam logic [4:0] ALLOW_HL  = 5'b00100;
   localparam logic [4:0] ALLOW_SP  = 5'b01000;
   localparam logic [4:0] ALLOW_PSW = 5'b10000;
   localparam logic [4:0] ALLOW_STD = ALLOW_BC | ALLOW_DE | ALLOW_HL | ALLOW_SP;
   localparam logic [4:0] ALLOW_STK = ALLOW_BC | ALLOW_DE | ALLOW_HL | ALLOW_PSW;

   kind_type   kind;
   logic [7:0] base;
   logic       reg_at_bit3;
   logic [4:0] allow;
   logic [2:0] r1;
   logic       r1_ok;
   logic [2:0] r2;
   logic       r2_ok;
   logic [1:0] rp;
   logic       rp_ok;
   logic       byte_ok;

   // Mnemonic lookup.
   always_comb begin
      kind        = K_NONE;
      base        = 8'h00;
      reg_at_bit3 = 1'b0;
      allow       = ALLOW_STD;
      case (req.mnemonic)
         "CMA  ": begin kind = K_IMPLIED; base = 8'h2F; end
         "CMC  ": begin kind = K_IMPLIED; base = 8'h3F; end
         "DAA  ": begin kind = K_IMPLIED; base = 8'h27; end
         "DI   ": begin kind = K_IMPLIED; base = 8'hF3; end
         "EI   ": begin kind = K_IMPLIED; base = 8'hFB; end
         "HLT  ": begin kind = K_IMPLIED; base = 8'h76; end
         "NOP  ": begin kind = K_IMPLIED; base = 8'h00; end
         "PCHL ": begin kind = K_IMPLIED; base = 8'hE9; end
         "RAL  ": begin kind = K_IMPLIED; base = 8'h17; end
         "RAR  ": begin kind = K_IMPLIED; base = 8'h1F; end
         "RC   ": begin kind = K_IMPLIED; base = 8'hD8; end
         "RET  ": begin kind = K_IMPLIED; base = 8'hC9; end
         "RLC  ": begin kind = K_IMPLIED; base = 8'h07; end
         "RM   ": begin kind = K_IMPLIED; base = 8'hF8; end
         "RNC  ": begin kind = K_IMPLIED; base = 8'hD0; end
         "RNZ  ": begin kind = K_IMPLIED; base = 8'hC0; end
         "RP   ": begin kind = K_IMPLIED; base = 8'hF0; end
         "RPE  ": begin kind = K_IMPLIED; base = 8'hE8; end
         "RPO  ": begin kind = K_IMPLIED; base = 8'hE0; end
         "RRC  ": begin kind = K_IMPLIED; base = 8'h0F; end
         "RZ   ": begin kind = K_IMPLIED; base = 8'hC8; end
         "SPHL ": begin kind = K_IMPLIED; base = 8'hF9; end
         "STC  ": begin kind = K_IMPLIED; base = 8'h37; end
         "XCHG ": begin kind = K_IMPLIED; base = 8'hEB; end
         "XTHL ": begin kind = K_IMPLIED; base = 8'hE3; end
         "ADC  ": begin kind = K_REG; base = 8'h88; end
         "ADD  ": begin kind = K_REG; base = 8'h80; end
         "ANA  ": begin kind = K_REG; base = 8'hA0; end
         "CMP  ": begin kind = K_REG; base = 8'hB8; end
         "DCR  ": begin kind = K_REG; base = 8'h05; reg_at_bit3 = 1'b1; end
         "INR  ": begin kind = K_REG; base = 8'h04; reg_at_bit3 = 1'b1; end
         "ORA  ": begin kind = K_REG; base = 8'hB0; end
         "SBB  ": begin kind = K_REG; base = 8'h98; end
         "SUB  ": begin kind = K_REG; base = 8'h90; end
         "XRA  ": begin kind = K_REG; base = 8'hA8; end
         "DAD  ": begin kind = K_PAIR; base = 8'h09; end
         "DCX  ": begin kind = K_PAIR; base = 8'h0B; end
         "INX  ": begin kind = K_PAIR; base = 8'h03; end
         "LDAX ": begin kind = K_PAIR; base = 8'h0A; allow = ALLOW_BC | ALLOW_DE; end
         "STAX ": begin kind = K_PAIR; base = 8'h02; allow = ALLOW_BC | ALLOW_DE; end
         "POP  ": begin kind = K_PAIR; base = 8'hC1; allow = ALLOW_STK; end
         "PUSH ": begin kind = K_PAIR; base = 8'hC5; allow = ALLOW_STK; end
         "ACI  ": begin kind = K_BYTE; base = 8'hCE; end
         "ADI  ": begin kind = K_BYTE; base = 8'hC6; end
         "ANI  ": begin kind = K_BYTE; base = 8'hE6; end
         "CPI  ": begin kind = K_BYTE; base = 8'hFE; end
         "IN   ": begin kind = K_BYTE; base = 8'hDB; end
         "ORI  ": begin kind = K_BYTE; base = 8'hF6; end
         "OUT  ": begin kind = K_BYTE; base = 8'hD3; end
         "SBI  ": begin kind = K_BYTE; base = 8'hDE; end
         "SUI  ": begin kind = K_BYTE; base = 8'hD6; end
         "XRI  ": begin kind = K_BYTE; base = 8'hEE; end
         "CALL ": begin kind = K_WORD; base = 8'hCD; end
         "CC   ": begin kind = K_WORD; base = 8'hDC; end
         "CM   ": begin kind = K_WORD; base = 8'hFC; end
         "CNC  ": begin kind = K_WORD; base = 8'hD4; end
         "CNZ  ": begin kind = K_WORD; base = 8'hC4; end
         "CP   ": begin kind = K_WORD; base = 8'hF4; end
         "CPE  ": begin kind = K_WORD; base = 8'hEC; end
         "CPO  ": begin kind = K_WORD; base = 8'hE4; end
         "CZ   ": begin kind = K_WORD; base = 8'hCC; end
         "JC   ": begin kind = K_WORD; base = 8'hDA; end
         "JM   ": begin kind = K_WORD; base = 8'hFA; end
         "JMP  ": begin kind = K_WORD; base = 8'hC3; end
         "JNC  ": begin kind = K_WORD; base = 8'hD2; end
         "JNZ  ": begin kind = K_WORD; base = 8'hC2; end
         "JP   ": begin kind = K_WORD; base = 8'hF2; end
         "JPE  ": begin kind = K_WORD; base = 8'hEA; end
         "JPO  ": begin kind = K_WORD; base = 8'hE2; end
         "JZ   ": begin kind = K_WORD; base = 8'hCA; end
         "LDA  ": begin kind = K_WORD; base = 8'h3A; end
         "LHLD ": begin kind = K_WORD; base = 8'h2A; end
         "STA  ": begin kind = K_WORD; base = 8'h32; end
         "SHLD ": begin kind = K_WORD; base = 8'h22; end
         "MOV  ": begin kind = K_MOV; base = 8'h40; end
         "MVI  ": begin kind = K_MVI; base = 8'h06; end
         "LXI  ": begin kind = K_LXI; base = 8'h01; end
         "RST  ": begin kind = K_RST; base = 8'hC7; end
         default: begin kind = K_NONE; end
      endcase
   end

   // 8-bit register names for both operands.
   always_comb begin
      r1_ok = 1'b1;
      case (req.first_operand)
         "B    ": r1 = 3'd0;
         "C    ": r1 = 3'd1;
         "D    ": r1 = 3'd2;
         "E    ": r1 = 3'd3;
         "H    ": r1 = 3'd4;
         "L    ": r1 = 3'd5;
         "M    ": r1 = 3'd6;
         "A    ": r1 = 3'd7;
         default: begin r1 = 3'd0; r1_ok = 1'b0; end
      endcase
   end

   always_comb begin
      r2_ok = 1'b1;
      case (req.second_operand)
         "B    ": r2 = 3'd0;
         "C    ": r2 = 3'd1;
         "D    ": r2 = 3'd2;
         "E    ": r2 = 3'd3;
         "H    ": r2 = 3'd4;
         "L    ": r2 = 3'd5;
         "M    ": r2 = 3'd6;
         "A    ": r2 = 3'd7;
         default: begin r2 = 3'd0; r2_ok = 1'b0; end
      endcase
   end

   // Register pairs, filtered by what the instruction allows.
   always_comb begin
      rp    = 2'd0;
      rp_ok = 1'b0;
      case (req.first_operand)
         "B    ": begin rp = 2'd0; rp_ok = allow[0]; end
         "D    ": begin rp = 2'd1; rp_ok = allow[1]; end
         "H    ": begin rp = 2'd2; rp_ok = allow[2]; end
         "SP   ": begin rp = 2'd3; rp_ok = allow[3]; end
         "PSW  ": begin rp = 2'd3; rp_ok = allow[4]; end
         default: begin rp = 2'd0; rp_ok = 1'b0; end
      endcase
   end

   assign byte_ok = (req.immediate[15:8] == 8'h00) || (req.immediate[15:8] == 8'hFF);

   always_comb begin
      enc.byte0  = 8'h00;
      enc.byte1  = req.immediate[7:0];
      enc.byte2  = req.immediate[15:8];
      enc.count  = 2'd1;
      enc.status = STATUS_OK;
      case (kind)
         K_IMPLIED: enc.byte0 = base;
         K_REG: begin
            if (!r1_ok) begin
               enc.status = STATUS_BAD_REG;
            end else if (reg_at_bit3) begin
               enc.byte0 = base | {2'b00, r1, 3'b000};
            end else begin
               enc.byte0 = base | {5'b00000, r1};
            end
         end
         K_PAIR: begin
            if (!rp_ok) begin
               enc.status = STATUS_BAD_REG;
            end else begin
               enc.byte0 = base | {2'b00, rp, 4'b0000};
            end
         end
         K_BYTE: begin
            if (!byte_ok) begin
               enc.status = STATUS_BAD_BYTE;
            end else begin
               enc.byte0 = base;
               enc.count = 2'd2;
            end
         end
         K_WORD: begin
            enc.byte0 = base;
            enc.count = 2'd3;
         end
         K_MOV: begin
            if (!r1_ok || !r2_ok) begin
               enc.status = STATUS_BAD_REG;
            end else begin
               enc.byte0 = base | {2'b00, r1, r2};
            end
         end
         K_MVI: begin
            // The register is checked before the immediate.
            if (!r1_ok) begin
               enc.status = STATUS_BAD_REG;
            end else if (!byte_ok) begin
               enc.status = STATUS_BAD_BYTE;
            end else begin
               enc.byte0 = base | {2'b00, r1, 3'b000};
               enc.count = 2'd2;
            end
         end
         K_LXI: begin
            if (!rp_ok) begin
               enc.status = STATUS_BAD_REG;
            end else begin
               enc.byte0 = base | {2'b00, rp, 4'b0000};
               enc.count = 2'd3;
            end
         end
         K_RST: begin
            if (|req.immediate[15:3]) begin
               enc.status = STATUS_BAD_RST;
            end else begin
               enc.byte0 = base | {2'b00, req.immediate[2:0], 3'b000};
            end
         end
         default: enc.status = STATUS_BAD_MNEM;
      endcase
   end

endmodule

### design/i8080ie_serializer.sv
// Holds one encoded instruction and sends its bytes one per cycle through the
// registered response port. Depends on i8080ie_pkg.
module i8080ie_serializer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  i8080ie_pkg::enc_type enc,
   output logic                 free,
   output logic                 rsp_strobe,
   output i8080ie_pkg::rsp_type rsp_data
);
   import i8080ie_pkg::*;

   enc_type    buf_ff;
   logic       buf_valid_ff;
   logic       buf_valid_in;
   logic [1:0] idx_ff;
   logic [1:0] idx_in;
   logic       rsp_valid_ff;
   rsp_type    rsp_ff;
   rsp_type    rsp_in;
   logic       is_last;
   logic [7:0] cur_byte;

   assign is_last = (idx_ff == (buf_ff.count - 2'd1));
   // The buffer sends one byte every cycle it is full, so it frees on its last.
   assign free    = !buf_valid_ff || is_last;

   always_comb begin
      case (idx_ff)
         2'd0:    cur_byte = buf_ff.byte0;
         2'd1:    cur_byte = buf_ff.byte1;
         2'd2:    cur_byte = buf_ff.byte2;
         default: cur_byte = 8'h00;
      endcase
   end

   always_comb begin
      rsp_in.code_byte = cur_byte;
      rsp_in.last_byte = is_last;
      rsp_in.status    = buf_ff.status;
      buf_valid_in     = buf_valid_ff;
      idx_in           = idx_ff;
      if (buf_valid_ff) begin
         if (is_last) begin
            buf_valid_in = load;
            idx_in       = 2'd0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end else begin
         buf_valid_in = load;
         idx_in       = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         buf_valid_ff <= buf_valid_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= buf_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         buf_ff <= enc;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      buf_valid_ff |-> (buf_ff.count != 2'd0) && (idx_ff < buf_ff.count))
      else $error("serializer index outside the instruction");

   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.last_byte |=> rsp_valid_ff)
      else $error("instruction bytes were not sent back to back");

   a_error_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.status != STATUS_OK)
      |-> rsp_ff.last_byte && (rsp_ff.code_byte == 8'h00))
      else $error("error response is not a single zero byte");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> free)
      else $error("buffer loaded while still sending");

endmodule

### design/i8080_instruction_encoder.sv
// Top level of the 8080 instruction encoder: request register, decoder and
// byte serializer. Depends on i8080ie_pkg, i8080ie_decoder, i8080ie_serializer.
//
// Usage:
//   A request (mnemonic, two operand names, evaluated immediate) is taken at a
//   rising edge where start is high and busy is low. Each instruction produces
//   one to three code bytes, immediates low byte first, or a single error
//   response with a zero code byte and a nonzero status.
//   Each response byte sits on rsp_data for exactly one cycle with rsp_strobe
//   high; last_byte marks the final byte. The receiver cannot stall.
//   Path: an accepted request waits in the request register, moves into the
//   serializer buffer once the serializer is free, and its first byte is then
//   registered onto rsp_data; the bytes of one instruction follow back to back.
//   Throughput: one output byte per cycle while the serializer holds an
//   instruction, and it takes the next instruction as it registers the last
//   byte of the current one. busy rises only when the request register is full
//   and the serializer still has bytes left of an earlier instruction; the
//   one-byte response port sets the request rate.
//   Reset (synchronous, active high) empties the request register and the
//   serializer; no response is issued until a new request arrives.
module i8080_instruction_encoder (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  i8080ie_pkg::req_type req_data,
   output logic                 rsp_strobe,
   output i8080ie_pkg::rsp_type rsp_data
);
   import i8080ie_pkg::*;

   req_type req_ff;
   logic    req_valid_ff;
   logic    req_valid_in;
   logic    accept;
   logic    move;
   logic    ser_free;
   enc_type enc;

   assign move   = req_valid_ff && ser_free;
   assign busy   = req_valid_ff && !ser_free;
   assign accept = start && !busy;

   assign req_valid_in = accept || (req_valid_ff && !move);

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
   end

   i8080ie_decoder u_decoder (
      .req (req_ff),
      .enc (enc)
   );

   i8080ie_serializer u_serializer (
      .clock      (clock),
      .reset      (reset),
      .load       (move),
      .enc        (enc),
      .free       (ser_free),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

### bench/tb_i8080_instruction_encoder.sv
// Self-checking bench for i8080_instruction_encoder: directed and random instructions,
// with each code byte predicted and compared as the block emits it.
// Depends on i8080ie_pkg and the encoder RTL.
module tb_i8080_instruction_encoder;
   timeunit 1ns;
   timeprecision 1ps;

   import i8080ie_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int TAIL_CYCLES = 20;
   localparam int PHASE_REQUESTS = 63;

   localparam logic [4:0] PAIR_BC = 5'b00001;
   localparam logic [4:0] PAIR_DE = 5'b00010;
   localparam logic [4:0] PAIR_HL = 5'b00100;
   localparam logic [4:0] PAIR_SP = 5'b01000;
   localparam logic [4:0] PAIR_PSW = 5'b10000;
   localparam logic [4:0] PAIRS_ARITH = PAIR_BC | PAIR_DE | PAIR_HL | PAIR_SP;
   localparam logic [4:0] PAIRS_STACK = PAIR_BC | PAIR_DE | PAIR_HL | PAIR_PSW;

   typedef enum {
      OP_IMPLIED, OP_ALU_REG, OP_INC_DEC, OP_PAIR, OP_BYTE_IMM,
      OP_WORD_IMM, OP_MOV, OP_MVI, OP_LXI, OP_RST
   } op_group_type;

   typedef struct {
      logic [39:0]  name;
      op_group_type group;
      logic [7:0]   opcode;
      logic [4:0]   pairs;
   } op_entry_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;

   op_entry_type op_table[$];
   req_type      pending_requests[$];
   rsp_type      expected_bytes[$];
   int           op_hits[int];
   int           status_hits[0:4] = '{default: 0};
   int           idle_phases[4] = '{0, 78, 25, 0};
   int           sender_idle_pct = 0;
   int           error_count = 0;
   int           accepted_requests = 0;
   int           checked_bytes = 0;
   int           stall_cycles = 0;

   i8080_instruction_encoder i_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic void add_op(logic [39:0] name, op_group_type group, logic [7:0] opcode,
                                  logic [4:0] pairs = '0);
      op_entry_type e;
      e.name = name;
      e.group = group;
      e.opcode = opcode;
      e.pairs = pairs;
      op_table.push_back(e);
   endfunction

   function automatic void build_op_table();
      add_op("CMA  ", OP_IMPLIED, 8'h2F); add_op("CMC  ", OP_IMPLIED, 8'h3F);
      add_op("DAA  ", OP_IMPLIED, 8'h27); add_op("DI   ", OP_IMPLIED, 8'hF3);
      add_op("EI   ", OP_IMPLIED, 8'hFB); add_op("HLT  ", OP_IMPLIED, 8'h76);
      add_op("NOP  ", OP_IMPLIED, 8'h00); add_op("PCHL ", OP_IMPLIED, 8'hE9);
      add_op("RAL  ", OP_IMPLIED, 8'h17); add_op("RAR  ", OP_IMPLIED, 8'h1F);
      add_op("RC   ", OP_IMPLIED, 8'hD8); add_op("RET  ", OP_IMPLIED, 8'hC9);
      add_op("RLC  ", OP_IMPLIED, 8'h07); add_op("RM   ", OP_IMPLIED, 8'hF8);
      add_op("RNC  ", OP_IMPLIED, 8'hD0); add_op("RNZ  ", OP_IMPLIED, 8'hC0);
      add_op("RP   ", OP_IMPLIED, 8'hF0); add_op("RPE  ", OP_IMPLIED, 8'hE8);
      add_op("RPO  ", OP_IMPLIED, 8'hE0); add_op("RRC  ", OP_IMPLIED, 8'h0F);
      add_op("RZ   ", OP_IMPLIED, 8'hC8); add_op("SPHL ", OP_IMPLIED, 8'hF9);
      add_op("STC  ", OP_IMPLIED, 8'h37); add_op("XCHG ", OP_IMPLIED, 8'hEB);
      add_op("XTHL ", OP_IMPLIED, 8'hE3);
      add_op("ADC  ", OP_ALU_REG, 8'h88); add_op("ADD  ", OP_ALU_REG, 8'h80);
      add_op("ANA  ", OP_ALU_REG, 8'hA0); add_op("CMP  ", OP_ALU_REG, 8'hB8);
      add_op("ORA  ", OP_ALU_REG, 8'hB0); add_op("SBB  ", OP_ALU_REG, 8'h98);
      add_op("SUB  ", OP_ALU_REG, 8'h90); add_op("XRA  ", OP_ALU_REG, 8'hA8);
      add_op("DCR  ", OP_INC_DEC, 8'h05); add_op("INR  ", OP_INC_DEC, 8'h04);
      add_op("DAD  ", OP_PAIR, 8'h09, PAIRS_ARITH);
      add_op("DCX  ", OP_PAIR, 8'h0B, PAIRS_ARITH);
      add_op("INX  ", OP_PAIR, 8'h03, PAIRS_ARITH);
      add_op("LDAX ", OP_PAIR, 8'h0A, PAIR_BC | PAIR_DE);
      add_op("STAX ", OP_PAIR, 8'h02, PAIR_BC | PAIR_DE);
      add_op("POP  ", OP_PAIR, 8'hC1, PAIRS_STACK);
      add_op("PUSH ", OP_PAIR, 8'hC5, PAIRS_STACK);
      add_op("ACI  ", OP_BYTE_IMM, 8'hCE); add_op("ADI  ", OP_BYTE_IMM, 8'hC6);
      add_op("ANI  ", OP_BYTE_IMM, 8'hE6); add_op("CPI  ", OP_BYTE_IMM, 8'hFE);
      add_op("IN   ", OP_BYTE_IMM, 8'hDB); add_op("ORI  ", OP_BYTE_IMM, 8'hF6);
      add_op("OUT  ", OP_BYTE_IMM, 8'hD3); add_op("SBI  ", OP_BYTE_IMM, 8'hDE);
      add_op("SUI  ", OP_BYTE_IMM, 8'hD6); add_op("XRI  ", OP_BYTE_IMM, 8'hEE);
      add_op("CALL ", OP_WORD_IMM, 8'hCD); add_op("CC   ", OP_WORD_IMM, 8'hDC);
      add_op("CM   ", OP_WORD_IMM, 8'hFC); add_op("CNC  ", OP_WORD_IMM, 8'hD4);
      add_op("CNZ  ", OP_WORD_IMM, 8'hC4); add_op("CP   ", OP_WORD_IMM, 8'hF4);
      add_op("CPE  ", OP_WORD_IMM, 8'hEC); add_op("CPO  ", OP_WORD_IMM, 8'hE4);
      add_op("CZ   ", OP_WORD_IMM, 8'hCC); add_op("JC   ", OP_WORD_IMM, 8'hDA);
      add_op("JM   ", OP_WORD_IMM, 8'hFA); add_op("JMP  ", OP_WORD_IMM, 8'hC3);
      add_op("JNC  ", OP_WORD_IMM, 8'hD2); add_op("JNZ  ", OP_WORD_IMM, 8'hC2);
      add_op("JP   ", OP_WORD_IMM, 8'hF2); add_op("JPE  ", OP_WORD_IMM, 8'hEA);
      add_op("JPO  ", OP_WORD_IMM, 8'hE2); add_op("JZ   ", OP_WORD_IMM, 8'hCA);
      add_op("LDA  ", OP_WORD_IMM, 8'h3A); add_op("LHLD ", OP_WORD_IMM, 8'h2A);
      add_op("STA  ", OP_WORD_IMM, 8'h32); add_op("SHLD ", OP_WORD_IMM, 8'h22);
      add_op("MOV  ", OP_MOV, 8'h40);
      add_op("MVI  ", OP_MVI, 8'h06);
      add_op("LXI  ", OP_LXI, 8'h01, PAIRS_ARITH);
      add_op("RST  ", OP_RST, 8'hC7);
   endfunction

   function automatic logic [39:0] reg_name(int idx);
      case (idx)
         0: return "B    ";
         1: return "C    ";
         2: return "D    ";
         3: return "E    ";
         4: return "H    ";
         5: return "L    ";
         6: return "M    ";
         default: return "A    ";
      endcase
   endfunction

   function automatic logic [39:0] pair_name(int idx);
      case (idx)
         0: return "B    ";
         1: return "D    ";
         2: return "H    ";
         3: return "SP   ";
         default: return "PSW  ";
      endcase
   endfunction

   function automatic int reg_index(logic [39:0] w);
      for (int i = 0; i < 8; i++)
         if (w == reg_name(i)) return i;
      return -1;
   endfunction

   // PSW and SP share the pair code 3; which of them is legal depends on the opcode.
   function automatic int pair_index(logic [39:0] w, logic [4:0] pairs);
      if ((pairs & PAIR_BC) != 0 && w == "B    ") return 0;
      if ((pairs & PAIR_DE) != 0 && w == "D    ") return 1;
      if ((pairs & PAIR_HL) != 0 && w == "H    ") return 2;
      if ((pairs & PAIR_PSW) != 0 && w == "PSW  ") return 3;
      if ((pairs & PAIR_SP) != 0 && w == "SP   ") return 3;
      return -1;
   endfunction

   function automatic void add_expected(logic [7:0] code, logic last, status_type status);
      rsp_type r;
      r.code_byte = code;
      r.last_byte = last;
      r.status = status;
      expected_bytes.push_back(r);
   endfunction

   function automatic void encode_instruction(req_type rq);
      int idx;
      int r;
      int s;
      logic byte_fits;
      op_entry_type e;
      idx = -1;
      foreach (op_table[i])
         if (op_table[i].name == rq.mnemonic) idx = i;
      if (idx < 0) begin
         add_expected(8'h00, 1'b1, STATUS_BAD_MNEM);
         return;
      end
      op_hits[idx] = 1;
      e = op_table[idx];
      // A byte immediate may be a sign-extended negative value.
      byte_fits = rq.immediate[15:8] == 8'h00 || rq.immediate[15:8] == 8'hFF;
      case (e.group)
         OP_IMPLIED: add_expected(e.opcode, 1'b1, STATUS_OK);
         OP_ALU_REG, OP_INC_DEC: begin
            r = reg_index(rq.first_operand);
            if (r < 0) add_expected(8'h00, 1'b1, STATUS_BAD_REG);
            else if (e.group == OP_ALU_REG) add_expected(e.opcode | 8'(r), 1'b1, STATUS_OK);
            else add_expected(e.opcode | 8'(r << 3), 1'b1, STATUS_OK);
         end
         OP_PAIR: begin
            r = pair_index(rq.first_operand, e.pairs);
            if (r < 0) add_expected(8'h00, 1'b1, STATUS_BAD_REG);
            else add_expected(e.opcode | 8'(r << 4), 1'b1, STATUS_OK);
         end
         OP_BYTE_IMM: begin
            if (!byte_fits) add_expected(8'h00, 1'b1, STATUS_BAD_BYTE);
            else begin
               add_expected(e.opcode, 1'b0, STATUS_OK);
               add_expected(rq.immediate[7:0], 1'b1, STATUS_OK);
            end
         end
         OP_WORD_IMM: begin
            add_expected(e.opcode, 1'b0, STATUS_OK);
            add_expected(rq.immediate[7:0], 1'b0, STATUS_OK);
            add_expected(rq.immediate[15:8], 1'b1, STATUS_OK);
         end
         OP_MOV: begin
            r = reg_index(rq.first_operand);
            s = reg_index(rq.second_operand);
            if (r < 0 || s < 0) add_expected(8'h00, 1'b1, STATUS_BAD_REG);
            else add_expected(e.opcode | 8'(r << 3) | 8'(s), 1'b1, STATUS_OK);
         end
         OP_MVI: begin
            // The register is checked before the immediate.
            r = reg_index(rq.first_operand);
            if (r < 0) add_expected(8'h00, 1'b1, STATUS_BAD_REG);
            else if (!byte_fits) add_expected(8'h00, 1'b1, STATUS_BAD_BYTE);
            else begin
               add_expected(e.opcode | 8'(r << 3), 1'b0, STATUS_OK);
               add_expected(rq.immediate[7:0], 1'b1, STATUS_OK);
            end
         end
         OP_LXI: begin
            r = pair_index(rq.first_operand, e.pairs);
            if (r < 0) add_expected(8'h00, 1'b1, STATUS_BAD_REG);
            else begin
               add_expected(e.opcode | 8'(r << 4), 1'b0, STATUS_OK);
               add_expected(rq.immediate[7:0], 1'b0, STATUS_OK);
               add_expected(rq.immediate[15:8], 1'b1, STATUS_OK);
            end
         end
         default: begin
            if (rq.immediate > 16'd7) add_expected(8'h00, 1'b1, STATUS_BAD_RST);
            else add_expected(e.opcode | {2'b00, rq.immediate[2:0], 3'b000}, 1'b1, STATUS_OK);
         end
      endcase
   endfunction

   function automatic logic [39:0] random_word40();
      return {8'($urandom_range(255)), 32'($urandom())};
   endfunction

   function automatic logic [39:0] random_register();
      int roll;
      roll = $urandom_range(99);
      if (roll < 88) return reg_name($urandom_range(7));
      if (roll < 94) return pair_name($urandom_range(4));
      return random_word40();
   endfunction

   function automatic logic [39:0] random_pair();
      int roll;
      roll = $urandom_range(99);
      if (roll < 90) return pair_name($urandom_range(4));
      if (roll < 95) return reg_name($urandom_range(7));
      return random_word40();
   endfunction

   function automatic logic [15:0] random_byte_value();
      int roll;
      roll = $urandom_range(99);
      if (roll < 50) return 16'($urandom_range(255));
      if (roll < 80) return {8'hFF, 8'($urandom_range(255))};
      return 16'($urandom());
   endfunction

   function automatic req_type random_request();
      req_type rq;
      op_entry_type e;
      int roll;
      roll = $urandom_range(99);
      rq.first_operand = random_word40();
      rq.second_operand = random_word40();
      rq.immediate = 16'($urandom());
      e = op_table[$urandom_range(op_table.size() - 1)];
      rq.mnemonic = e.name;
      if (roll < 88) begin
         case (e.group)
            OP_ALU_REG, OP_INC_DEC, OP_MOV, OP_MVI: rq.first_operand = random_register();
            OP_PAIR, OP_LXI: rq.first_operand = random_pair();
            default: ;
         endcase
         if (e.group == OP_MOV) rq.second_operand = random_register();
         if (e.group inside {OP_BYTE_IMM, OP_MVI}) rq.immediate = random_byte_value();
         if (e.group == OP_RST && $urandom_range(3) != 0)
            rq.immediate = 16'($urandom_range(7));
      end else if (roll < 94) begin
         // Near miss: a real mnemonic with one character replaced.
         rq.mnemonic[8 * $urandom_range(4) +: 8] = 8'($urandom_range(32, 90));
      end else begin
         rq.mnemonic = random_word40();
      end
      return rq;
   endfunction

   function automatic void queue_request(logic [39:0] m, logic [39:0] a, logic [39:0] b,
                                         logic [15:0] imm);
      req_type rq;
      rq.mnemonic = m;
      rq.first_operand = a;
      rq.second_operand = b;
      rq.immediate = imm;
      pending_requests.push_back(rq);
   endfunction

   task automatic wait_until_drained();
      while (pending_requests.size() != 0 || start || expected_bytes.size() != 0)
         @(negedge clock);
   endtask

   // Request driver: presents the next queued instruction, with random gaps when sender_idle_pct is nonzero.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            encode_instruction(req_data);
            accepted_requests++;
         end
         if (!start || !busy) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               req_data <= pending_requests.pop_front();
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Response monitor: each strobed byte is checked against the oldest prediction.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_bytes.size() == 0) begin
            $display("%0t: unexpected response: expected none, got code %h last %b status %0d",
                     $time, rsp_data.code_byte, rsp_data.last_byte, rsp_data.status);
            error_count++;
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_data.code_byte !== want.code_byte || rsp_data.last_byte !== want.last_byte
                || rsp_data.status !== want.status) begin
               $display({"%0t: mismatch: expected code %h last %b status %0d, ",
                         "got code %h last %b status %0d"},
                        $time, want.code_byte, want.last_byte, want.status,
                        rsp_data.code_byte, rsp_data.last_byte, rsp_data.status);
               error_count++;
            end
            status_hits[want.status]++;
            checked_bytes++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no request or response for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("tb_i8080_instruction_encoder NOT OK");
         $finish;
      end
   end

   initial begin
      build_op_table();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      queue_request("NOP  ", 40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF, 16'hFFFF);
      queue_request("XTHL ", '0, '0, '0);
      queue_request("ADC  ", "B    ", '0, '0);
      queue_request("DCR  ", "A    ", '0, '0);
      queue_request("INR  ", "M    ", '0, '0);
      queue_request("SUB  ", "SP   ", '0, '0);
      queue_request("DAD  ", "SP   ", '0, '0);
      queue_request("PUSH ", "PSW  ", '0, '0);
      queue_request("INX  ", "PSW  ", '0, '0);
      queue_request("LDAX ", "D    ", '0, '0);
      queue_request("STAX ", "H    ", '0, '0);
      queue_request("ADI  ", '0, '0, 16'hFF80);
      queue_request("CPI  ", '0, '0, 16'h0100);
      queue_request("IN   ", '0, '0, 16'h0012);
      queue_request("JMP  ", '0, '0, 16'h1234);
      queue_request("CALL ", '0, '0, 16'hFFFF);
      queue_request("LXI  ", "SP   ", '0, 16'hABCD);
      queue_request("LXI  ", "PSW  ", '0, 16'h0000);
      queue_request("MOV  ", "M    ", "A    ", '0);
      queue_request("MOV  ", "Q    ", "B    ", '0);
      queue_request("MOV  ", "A    ", "SP   ", '0);
      queue_request("MVI  ", "X    ", '0, 16'h1234);
      queue_request("MVI  ", "L    ", '0, 16'h1234);
      queue_request("MVI  ", "E    ", '0, 16'hFF00);
      queue_request("RST  ", '0, '0, 16'd7);
      queue_request("RST  ", '0, '0, 16'd8);
      queue_request("mov  ", "A    ", "B    ", '0);
      wait_until_drained();

      // Each phase ends with the sender holding off until every byte is back.
      foreach (idle_phases[p]) begin
         sender_idle_pct = idle_phases[p];
         repeat (PHASE_REQUESTS) pending_requests.push_back(random_request());
         wait_until_drained();
      end

      repeat (TAIL_CYCLES) @(negedge clock);
      if (expected_bytes.size() != 0) begin
         $display("%0t: %0d predicted bytes never arrived", $time, expected_bytes.size());
         error_count++;
      end
      $display("Encoded %0d instructions covering %0d of %0d mnemonics; %0d bytes checked.",
               accepted_requests, op_hits.num(), op_table.size(), checked_bytes);
      $display("Responses by status: ok %0d, mnemonic %0d, register %0d, byte %0d, rst %0d.",
               status_hits[0], status_hits[1], status_hits[2], status_hits[3], status_hits[4]);
      if (error_count == 0) begin
         $display("tb_i8080_instruction_encoder OK");
      end else begin
         $display("tb_i8080_instruction_encoder NOT OK");
      end
      $finish;
   end

endmodule

### i8080_instruction_encoder.f
design/i8080ie_pkg.sv
design/i8080ie_decoder.sv
design/i8080ie_serializer.sv
design/i8080_instruction_encoder.sv
bench/tb_i8080_instruction_encoder.sv
